### design/bvm_pkg.sv
// Shared types and constants for the battery voltage monitor.
package bvm_pkg;

  localparam int WINDOW_LEN_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int FUNC_W    = 2;
  localparam int VOLT_W    = 8;
  localparam int OHM_W     = CFG_W + 1;
  localparam int LIM_W     = 8;

  // voltage quotient bits below the saturation check
  localparam int VDIV_BITS = 8;
  localparam int VSCALE    = 33;
  localparam logic [VOLT_W-1:0] VOLT_SAT = 8'hFF;

  localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PWR_ON  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PWR_OFF = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_HIGH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd3;

  localparam logic [CFG_W-1:0] JUMP_LIMIT_RST = 10'd50;
  localparam logic [CFG_W-1:0] DIV_LOW_RST    = 10'd100;
  localparam logic [CFG_W-1:0] DIV_HIGH_RST   = 10'd402;
  localparam logic [LIM_W-1:0] LOW_LIMIT_RST  = 8'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_UPD,
    ST_MUL1,
    ST_MUL2,
    ST_VSTART,
    ST_VDIV,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

### design/bvm_div.sv
// Restoring divider, one quotient bit per cycle after an overflow check.
module bvm_div import bvm_pkg::*; #(
  parameter int DIV_W = 48,
  parameter int QUO_W = SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [$clog2(QUO_W+1)-1:0]   nbits,
  input  logic [DIV_W-1:0]             num,
  input  logic [DIV_W-1:0]             den,
  output logic [QUO_W-1:0]             quo,
  output div_stat_t                    stat
);

  localparam int CNT_W = $clog2(QUO_W+1);

  logic             busy_r, done_r, first_r, ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r, dsh_r;
  logic [QUO_W-1:0] quo_r;
  logic             ge;

  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
        cnt_r   <= nbits;
      end else if (busy_r) begin
        if (first_r) begin
          first_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= den << nbits;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dsh_r <= dsh_r >> 1;
      if (first_r) begin
        // quotient would not fit in nbits
        ovf_r <= ge;
      end else begin
        quo_r <= {quo_r[QUO_W-2:0], ge};
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
      end
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

### design/bvm_window.sv
// Sample ring memory with per-entry valid bits and a restart fill value.
module bvm_window import bvm_pkg::*; #(
  parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(WINDOW_LEN)-1:0]  raddr,
  output logic [SAMPLE_BITS-1:0]         rdata,
  input  logic                           we,
  input  logic [$clog2(WINDOW_LEN)-1:0]  waddr,
  input  logic [SAMPLE_BITS-1:0]         wdata,
  input  logic                           clr,
  input  logic [SAMPLE_BITS-1:0]         clr_val
);

  logic [SAMPLE_BITS-1:0] mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]  vld_r;
  logic [SAMPLE_BITS-1:0] fill_r;
  logic [SAMPLE_BITS-1:0] rd_r;
  logic                   rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  // an entry not written since the last restart reads as the fill value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      fill_r <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[raddr];
      if (clr) begin
        vld_r  <= '0;
        fill_r <= clr_val;
      end else if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rvld_r ? rd_r : fill_r;

endmodule

### design/battery_voltage_monitor_top.sv
// Battery voltage monitor: sequencer, config registers and datapath around a restoring divider.
// Order, one beat at a time: a sample beat runs ST_AVG, ST_UPD, ST_MUL1, ST_MUL2, ST_VSTART,
//   ST_VDIV, ST_FIN; a power command beat goes straight to ST_DONE. out_valid is registered
//   from ST_DONE once the output is free and leaves on an edge with out_ready high. The
//   average is a reciprocal multiply; the divider scales the voltage in VDIV_BITS + 1 steps (9).
// Reset: synchronous active-low rst_n clears window, sum, slot, power and config to defaults.
module battery_voltage_monitor_top import bvm_pkg::*; #(
  parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VOLT_W-1:0]      out_voltage,
  output logic                   out_power_on,
  output logic                   out_shutoff,
  output logic                   out_restarted,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int SUM_W  = $clog2(WINDOW_LEN * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int P1_W   = SUM_W + 6;
  localparam int NUM_W  = P1_W + OHM_W;
  localparam int LWL_W  = CFG_W + $clog2(WINDOW_LEN + 1);
  localparam int DEN_W  = LWL_W + SAMPLE_BITS;
  localparam int DIV_W  = (NUM_W > DEN_W + VDIV_BITS) ? NUM_W : DEN_W + VDIV_BITS;
  localparam int CNT_W  = $clog2(VDIV_BITS + 1);
  localparam int CMP_W  = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;

  // average by reciprocal multiply, exact for every sum below 2^SUM_W
  localparam int AVG_SH = SUM_W + $clog2(WINDOW_LEN);
  localparam int RCP_W  = SUM_W + 2;
  localparam int PRD_W  = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] AVG_RCP =
    RCP_W'(((longint'(1) << AVG_SH) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN));

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] jump_r, low_r, high_r;
  logic [LIM_W-1:0] lim_r;

  logic [FUNC_W-1:0]      func_r;
  logic [SAMPLE_BITS-1:0] samp_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic                   power_r, power_nxt;
  logic [VOLT_W-1:0]      last_volt_r, vnew;
  logic                   restart_r, shut_r;
  logic [P1_W-1:0]        p1_r;
  logic [OHM_W-1:0]       ohm_r;
  logic [LWL_W-1:0]       lowwl_r;
  logic [NUM_W-1:0]       num_r;
  logic [SAMPLE_BITS-1:0] avg_r;
  logic [PRD_W-1:0]       avg_prd;

  logic                   out_valid_r, out_power_r, out_shut_r, out_restart_r;
  logic [VOLT_W-1:0]      out_volt_r;

  logic                   accept, out_free, restart;
  logic [CMP_W-1:0]       avg_x, samp_x, diff;
  logic [SAMPLE_BITS-1:0] old_entry;

  logic                   div_start;
  logic [CNT_W-1:0]       div_nbits;
  logic [DIV_W-1:0]       div_num, div_den;
  logic [VDIV_BITS-1:0]   div_q;
  div_stat_t              div_st;

  assign accept    = in_valid && in_ready;
  assign in_ready  = rst_n && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = rst_n;
  assign slot_nxt  = (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_r <= JUMP_LIMIT_RST;
      low_r  <= DIV_LOW_RST;
      high_r <= DIV_HIGH_RST;
      lim_r  <= LOW_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_JUMP_LIMIT: jump_r <= cfg_data;
        REG_DIV_LOW:    low_r  <= cfg_data;
        REG_DIV_HIGH:   high_r <= cfg_data;
        REG_LOW_LIMIT:  lim_r  <= cfg_data[LIM_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_func == FUNC_SAMPLE) ? ST_AVG : ST_DONE;
        end
      end
      ST_AVG:    state_nxt = ST_UPD;
      ST_UPD:    state_nxt = ST_MUL1;
      ST_MUL1:   state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_VSTART;
      ST_VSTART: state_nxt = ST_VDIV;
      ST_VDIV: begin
        if (div_st.done) state_nxt = ST_FIN;
      end
      ST_FIN:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // voltage divide starts from ST_VSTART
  assign div_start = (state_r == ST_VSTART);
  assign div_num   = DIV_W'(num_r);
  assign div_den   = DIV_W'(lowwl_r) << SAMPLE_BITS;
  assign div_nbits = CNT_W'(VDIV_BITS);

  bvm_div #(
    .DIV_W (DIV_W),
    .QUO_W (VDIV_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .nbits (div_nbits),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .stat  (div_st)
  );

  bvm_window #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .raddr   (slot_nxt),
    .rdata   (old_entry),
    .we      ((state_r == ST_UPD) && !restart),
    .waddr   (slot_nxt),
    .wdata   (samp_r),
    .clr     ((state_r == ST_UPD) && restart),
    .clr_val (samp_r)
  );

  assign avg_prd = PRD_W'(sum_r) * PRD_W'(AVG_RCP);
  assign avg_x   = CMP_W'(avg_r);
  assign samp_x  = CMP_W'(samp_r);
  assign diff    = (samp_x > avg_x) ? samp_x - avg_x : avg_x - samp_x;
  assign restart = (diff > CMP_W'(jump_r));
  assign vnew    = div_st.ovf ? VOLT_SAT : div_q[VOLT_W-1:0];

  always_comb begin
    priority if (func_r == FUNC_PWR_ON) begin
      power_nxt = 1'b1;
    end else if (func_r == FUNC_PWR_OFF) begin
      power_nxt = 1'b0;
    end else if (func_r == FUNC_SAMPLE) begin
      power_nxt = power_r && !shut_r;
    end else begin
      power_nxt = power_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      slot_r      <= '0;
      power_r     <= 1'b0;
      last_volt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_UPD) begin
        if (restart) begin
          sum_r  <= SUM_W'(samp_r) * SUM_W'(WINDOW_LEN);
          slot_r <= '0;
        end else begin
          sum_r  <= sum_r - SUM_W'(old_entry) + SUM_W'(samp_r);
          slot_r <= slot_nxt;
        end
      end
      if (state_r == ST_FIN) begin
        last_volt_r <= vnew;
      end
      if ((state_r == ST_DONE) && out_free) begin
        power_r     <= power_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= in_func;
      samp_r    <= in_sample;
      restart_r <= 1'b0;
      shut_r    <= 1'b0;
    end
    if (state_r == ST_AVG) begin
      avg_r <= SAMPLE_BITS'(avg_prd >> AVG_SH);
    end
    if (state_r == ST_UPD) begin
      restart_r <= restart;
    end
    if (state_r == ST_MUL1) begin
      p1_r    <= P1_W'(sum_r) * P1_W'(VSCALE);
      ohm_r   <= OHM_W'(low_r) + OHM_W'(high_r);
      lowwl_r <= LWL_W'(low_r) * LWL_W'(WINDOW_LEN);
    end
    if (state_r == ST_MUL2) begin
      num_r <= NUM_W'(p1_r) * NUM_W'(ohm_r);
    end
    if (state_r == ST_FIN) begin
      shut_r <= power_r && (lim_r != '0) && (vnew < lim_r);
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_volt_r    <= last_volt_r;
      out_power_r   <= power_nxt;
      out_shut_r    <= shut_r;
      out_restart_r <= restart_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_voltage   = out_volt_r;
  assign out_power_on  = out_power_r;
  assign out_shutoff   = out_shut_r;
  assign out_restarted = out_restart_r;

`ifndef SYNTHESIS
  a_shut_cuts_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_shutoff |-> !out_power_on)
    else $error("shutoff reported with power still on");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == ST_VDIV))
    else $error("divider finished while sequencer not waiting");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second beat taken while first still in work");

  a_shut_needs_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_shutoff |-> (lim_r != '0))
    else $error("shutoff with limit disabled");
`endif

endmodule

### tb/sv/tb_battery_voltage_monitor_top.sv
// Self-checking testbench for the battery voltage monitor: beat driver, result monitor, predictor.
module tb_battery_voltage_monitor_top;
  import bvm_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int IDLE_MAX = 18;
  localparam int NUM_PHASES = 9;
  localparam int BEATS_PER_PHASE = 195;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [FUNC_W-1:0]          func;
    logic [SAMPLE_BITS_DEF-1:0] sample;
    int                         gap;
  } beat_t;

  typedef struct {
    logic [VOLT_W-1:0] voltage;
    logic              power_on;
    logic              shutoff;
    logic              restarted;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_W-1:0] in_func = FUNC_SAMPLE;
  logic [SAMPLE_BITS_DEF-1:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [VOLT_W-1:0] out_voltage;
  logic out_power_on;
  logic out_shutoff;
  logic out_restarted;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_JUMP_LIMIT;
  logic [CFG_W-1:0] cfg_data = '0;

  battery_voltage_monitor_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_voltage  (out_voltage),
    .out_power_on (out_power_on),
    .out_shutoff  (out_shutoff),
    .out_restarted(out_restarted),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // predictor state and register shadow
  logic [SAMPLE_BITS_DEF-1:0] win [WINDOW_LEN_DEF];
  logic [12:0] win_sum;
  logic [2:0] win_slot;
  logic pwr;
  logic [VOLT_W-1:0] held_volt;
  logic [CFG_W-1:0] jump_lim;
  logic [CFG_W-1:0] div_low;
  logic [CFG_W-1:0] div_high;
  logic [LIM_W-1:0] low_lim;

  beat_t pending_beats[$];
  reading_t expected_readings[$];
  int issued_beats = 0;
  int accepted_beats = 0;
  int checked_readings = 0;
  int restarts_seen = 0;
  int cutoffs_seen = 0;
  int cfg_writes = 0;
  int errors = 0;
  int send_idle_max = 0;
  int recv_idle_max = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1500000;
    $display("battery_voltage_monitor_top regression: fail");
    $finish;
  end

  function automatic reading_t predict_reading(input logic [FUNC_W-1:0] func,
                                               input logic [SAMPLE_BITS_DEF-1:0] smp);
    reading_t r;
    logic [12:0] avg;
    logic [12:0] delta;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    r.shutoff = 1'b0;
    r.restarted = 1'b0;
    case (func)
      FUNC_SAMPLE: begin
        avg = 13'(win_sum / WINDOW_LEN_DEF);
        delta = (smp > avg) ? smp - avg : avg - smp;
        if (delta > jump_lim) begin
          foreach (win[i]) win[i] = smp;
          win_sum = 13'(smp * WINDOW_LEN_DEF);
          win_slot = '0;
          r.restarted = 1'b1;
          restarts_seen++;
        end else begin
          win_slot = win_slot + 1'b1;
          win_sum = win_sum - win[win_slot] + smp;
          win[win_slot] = smp;
        end
        if (div_low == 0) begin
          held_volt = VOLT_SAT;
        end else begin
          num = 64'(win_sum) * VSCALE * (64'(div_low) + 64'(div_high));
          den = (64'd1 << SAMPLE_BITS_DEF) * WINDOW_LEN_DEF * 64'(div_low);
          q = num / den;
          held_volt = (q > 255) ? VOLT_SAT : q[VOLT_W-1:0];
        end
        if (pwr && low_lim != 0 && held_volt < low_lim) begin
          pwr = 1'b0;
          r.shutoff = 1'b1;
          cutoffs_seen++;
        end
      end
      FUNC_PWR_ON: pwr = 1'b1;
      FUNC_PWR_OFF: pwr = 1'b0;
      default: ;
    endcase
    r.voltage = held_volt;
    r.power_on = pwr;
    return r;
  endfunction

  // beat driver: stage the next beat, wait out its gap, hold valid until accepted
  beat_t staged_beat;
  logic staged = 1'b0;
  int wait_left = 0;

  always @(posedge clk) begin
    logic raise;
    if (!rst_n) begin
      foreach (win[i]) win[i] = '0;
      win_sum = '0;
      win_slot = '0;
      pwr = 1'b0;
      held_volt = '0;
      jump_lim = JUMP_LIMIT_RST;
      div_low = DIV_LOW_RST;
      div_high = DIV_HIGH_RST;
      low_lim = LOW_LIMIT_RST;
      staged = 1'b0;
      wait_left = 0;
      in_valid <= 1'b0;
    end else begin
      raise = in_valid;
      if (in_valid && in_ready) begin
        expected_readings.push_back(predict_reading(in_func, in_sample));
        accepted_beats++;
        raise = 1'b0;
      end
      if (!raise) begin
        if (!staged && pending_beats.size() > 0) begin
          staged_beat = pending_beats.pop_front();
          staged = 1'b1;
          wait_left = staged_beat.gap;
        end
        if (staged) begin
          if (wait_left == 0) begin
            in_func <= staged_beat.func;
            in_sample <= staged_beat.sample;
            raise = 1'b1;
            staged = 1'b0;
          end else begin
            wait_left--;
          end
        end
      end
      in_valid <= raise;
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  // result monitor: check each beat, then stall ready for a drawn number of cycles
  int hold_left = 0;

  always @(posedge clk) begin
    logic rdy;
    reading_t want;
    if (!rst_n) begin
      hold_left = 0;
      out_ready <= 1'b0;
    end else begin
      rdy = out_ready;
      if (out_valid && out_ready) begin
        checked_readings++;
        if (expected_readings.size() == 0) begin
          report_field("unexpected result, voltage", -1, out_voltage);
        end else begin
          want = expected_readings.pop_front();
          if (out_voltage !== want.voltage)
            report_field("voltage", want.voltage, out_voltage);
          if (out_power_on !== want.power_on)
            report_field("power_on", want.power_on, out_power_on);
          if (out_shutoff !== want.shutoff)
            report_field("shutoff", want.shutoff, out_shutoff);
          if (out_restarted !== want.restarted)
            report_field("restarted", want.restarted, out_restarted);
        end
        hold_left = (recv_idle_max == 0) ? 0 : $urandom_range(0, recv_idle_max);
        rdy = (hold_left == 0);
      end else if (!out_ready) begin
        if (hold_left == 0) rdy = 1'b1;
        else hold_left--;
      end
      out_ready <= rdy;
    end
  end

  task automatic add_beat(input logic [FUNC_W-1:0] func, input int smp);
    beat_t b;
    b.func = func;
    b.sample = SAMPLE_BITS_DEF'(smp);
    b.gap = (send_idle_max == 0) ? 0 : $urandom_range(0, send_idle_max);
    pending_beats.push_back(b);
    issued_beats++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_JUMP_LIMIT: jump_lim = CFG_W'(val);
      REG_DIV_LOW: div_low = CFG_W'(val);
      REG_DIV_HIGH: div_high = CFG_W'(val);
      REG_LOW_LIMIT: low_lim = val[LIM_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (accepted_beats != issued_beats || expected_readings.size() != 0);
  endtask

  // mostly a random walk of the sample level, with jumps, extremes and command beats mixed in
  task automatic queue_random_beats(input int count);
    int r;
    int lvl;
    int swing;
    int noise;
    lvl = $urandom_range(0, 1023);
    repeat (count) begin
      r = $urandom_range(0, 99);
      noise = $urandom_range(0, 1023);
      if (r < 12) begin
        add_beat(FUNC_PWR_ON, noise);
      end else if (r < 19) begin
        add_beat(FUNC_PWR_OFF, noise);
      end else if (r < 24) begin
        add_beat(FUNC_UNUSED, noise);
      end else begin
        r = $urandom_range(0, 99);
        swing = (jump_lim + 3 > 80) ? 80 : jump_lim + 3;
        if (r < 7) lvl = noise;
        else if (r < 10) lvl = ($urandom_range(0, 1) == 1) ? 1023 : 0;
        else lvl = lvl + int'($urandom_range(0, 2 * swing)) - swing;
        if (lvl < 0) lvl = 0;
        if (lvl > 1023) lvl = 1023;
        add_beat(FUNC_SAMPLE, lvl);
      end
    end
  endtask

  initial begin
    int phase_cfg [NUM_PHASES][4];
    phase_cfg = '{
      '{50, 100, 402, 100},
      '{0, 1, 0, 1023},
      '{1023, 1000, 1000, 30},
      '{20, 0, 500, 10},
      '{100, 1, 1023, 200},
      '{0, 0, 0, 0},
      '{64, 1023, 1023, 0},
      '{5, 1000, 0, 853},
      '{0, 0, 0, 0}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: commands, restart boundary and extremes at reset settings
    add_beat(FUNC_UNUSED, 1023);
    add_beat(FUNC_PWR_ON, 0);
    add_beat(FUNC_PWR_OFF, 0);
    add_beat(FUNC_SAMPLE, 0);
    add_beat(FUNC_SAMPLE, 1023);
    add_beat(FUNC_SAMPLE, 1023);
    add_beat(FUNC_SAMPLE, 1000);
    add_beat(FUNC_SAMPLE, 973);
    add_beat(FUNC_UNUSED, 0);
    add_beat(FUNC_SAMPLE, 0);
    add_beat(FUNC_SAMPLE, 50);
    add_beat(FUNC_SAMPLE, 57);
    add_beat(FUNC_PWR_ON, 1023);
    wait_drained();

    // directed: low-voltage cutoff and re-arm
    send_idle_max = IDLE_MAX;
    recv_idle_max = IDLE_MAX;
    write_reg(REG_LOW_LIMIT, 100);
    add_beat(FUNC_PWR_ON, 0);
    add_beat(FUNC_SAMPLE, 1023);
    add_beat(FUNC_SAMPLE, 0);
    add_beat(FUNC_SAMPLE, 0);
    add_beat(FUNC_PWR_ON, 0);
    add_beat(FUNC_UNUSED, 0);
    add_beat(FUNC_SAMPLE, 0);
    add_beat(FUNC_PWR_OFF, 0);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 5 || p == 8) begin
        phase_cfg[p][0] = $urandom_range(0, 1023);
        phase_cfg[p][1] = $urandom_range(0, 1023);
        phase_cfg[p][2] = $urandom_range(0, 1023);
        phase_cfg[p][3] = $urandom_range(0, 1023);
      end
      write_reg(REG_JUMP_LIMIT, phase_cfg[p][0]);
      write_reg(REG_DIV_LOW, phase_cfg[p][1]);
      write_reg(REG_DIV_HIGH, phase_cfg[p][2]);
      write_reg(REG_LOW_LIMIT, phase_cfg[p][3]);
      send_idle_max = (p % 3 == 1) ? 0 : IDLE_MAX;
      recv_idle_max = (p % 4 == 1 || p == 6) ? 0 : IDLE_MAX;
      queue_random_beats(BEATS_PER_PHASE);
      // hold new settings until every reading of this phase is back
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d beats and %0d checked readings over %0d register writes,",
             accepted_beats, checked_readings, cfg_writes);
    $display("with %0d window restarts and %0d low-voltage cutoffs predicted.",
             restarts_seen, cutoffs_seen);
    if (errors == 0 && expected_readings.size() == 0)
      $display("battery_voltage_monitor_top regression: pass");
    else
      $display("battery_voltage_monitor_top regression: fail");
    $finish;
  end

endmodule
